### src/arp_pkg.sv
// Shared types, codes and constants of the MIDI note arpeggiator.
// Used by the controller, the datapath, the divider and the top level.
// Depends on nothing.
package arp_pkg;

	localparam int MODE_W     = 2;
	localparam int NOTE_W     = 7;
	localparam int PLAY_W     = 8;
	localparam int PATTERN_W  = 3;
	localparam int SPAN_W     = 3;
	localparam int TPS_W      = 24;
	localparam int LCG_W      = 32;
	localparam int OCT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int SEMITONES  = 12;
	localparam int LCG_HI_SHIFT = 16;

	localparam logic [LCG_W-1:0] LCG_MUL  = 32'd1103515245;
	localparam logic [LCG_W-1:0] LCG_ADD  = 32'd12345;
	localparam logic [LCG_W-1:0] LCG_SEED = 32'hDEADBEEF;

	localparam logic [SPAN_W-1:0] SPAN_MIN   = 3'd1;
	localparam logic [SPAN_W-1:0] SPAN_MAX   = 3'd4;
	localparam logic [SPAN_W-1:0] SPAN_RESET = 3'd1;
	localparam logic [TPS_W-1:0]  TPS_RESET  = 24'd125;

	// Event kinds carried with each request.
	localparam logic [MODE_W-1:0] KIND_ON   = 2'd0;
	localparam logic [MODE_W-1:0] KIND_OFF  = 2'd1;
	localparam logic [MODE_W-1:0] KIND_TICK = 2'd2;

	// Step patterns.
	localparam logic [PATTERN_W-1:0] PAT_UP     = 3'd0;
	localparam logic [PATTERN_W-1:0] PAT_DOWN   = 3'd1;
	localparam logic [PATTERN_W-1:0] PAT_UPDOWN = 3'd2;
	localparam logic [PATTERN_W-1:0] PAT_RANDOM = 3'd3;
	localparam logic [PATTERN_W-1:0] PAT_PLAYED = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TPS     = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_RD,
		OP_SCAN_CHK,
		OP_INS_RD,
		OP_INS_WR,
		OP_INS_NOTE,
		OP_REM_RD,
		OP_REM_WR,
		OP_REM_END,
		OP_TICK,
		OP_DIV_SP_TOTAL,
		OP_DIV_P_N,
		OP_DIV_SP_N,
		OP_DIV_LCG_N,
		OP_DIV_LCGH_S,
		OP_TAKE_P,
		OP_TAKE_UPDN,
		OP_TAKE_RIDX,
		OP_TAKE_ROCT,
		OP_TAKE_ASPL,
		OP_LCG,
		OP_BOUNCE,
		OP_FIXED,
		OP_PICK_RD,
		OP_PICK_NOTE,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_INS_RD,
		ST_INS_WR,
		ST_REM_RD,
		ST_REM_WR,
		ST_TICK,
		ST_STEP,
		ST_LCG,
		ST_DIV1,
		ST_WAIT1,
		ST_TAKE1,
		ST_DIV2,
		ST_WAIT2,
		ST_TAKE2,
		ST_BOUNCE,
		ST_FIXED,
		ST_PICK_RD,
		ST_PICK_NOTE,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
	} arp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0]    kind;
		logic [PATTERN_W-1:0] pattern;
		logic                 n_zero;
		logic                 n_full;
		logic                 match;
		logic                 last;
		logic                 at_pos;
		logic                 rem_end;
		logic                 step_go;
		logic                 div_done;
		logic                 out_free;
	} arp_sts_t;

	function automatic logic [OCT_W-1:0] octave_offset(input logic [1:0] k);
		return OCT_W'(k) * OCT_W'(SEMITONES);
	endfunction

endpackage

### src/arp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the sorted note table. Depends on nothing.
module arp_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/arp_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Shared by all modulo and divide steps of the arpeggiator. Depends on arp_pkg.
module arp_div #(
	parameter int DW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [arp_pkg::LCG_W-1:0]  dividend,
	input  logic [DW-1:0]              divisor,
	output logic                       done,
	output logic [arp_pkg::LCG_W-1:0]  quot,
	output logic [DW-1:0]              rem
);

	localparam int CW = $clog2(arp_pkg::LCG_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic [arp_pkg::LCG_W-1:0] quot_q;
	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             den_q;
	logic [DW:0]               trial;
	logic [DW:0]               diff;
	logic                      fits;

	assign trial = {rem_q, quot_q[arp_pkg::LCG_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(arp_pkg::LCG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[arp_pkg::LCG_W-2:0], fits};
			rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

### src/arp_dp.sv
// Datapath of the arpeggiator: configuration, note table, step state, output register.
// Carries out one command of the controller per cycle. Depends on arp_pkg, arp_ram, arp_div.
module arp_dp #(
	parameter int MAX_NOTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  arp_pkg::arp_cmd_t             cmd,
	output arp_pkg::arp_sts_t             sts,
	input  logic [arp_pkg::MODE_W-1:0]    in_mode,
	input  logic [arp_pkg::NOTE_W-1:0]    in_note,
	input  logic                          cfg_we,
	input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_nvalid,
	output logic [arp_pkg::PLAY_W-1:0]    out_note,
	output logic                          out_started,
	output logic [$clog2(MAX_NOTES+1)-1:0] out_count
);

	localparam int NW = $clog2(MAX_NOTES + 1);
	localparam int IW = $clog2(MAX_NOTES);
	localparam int SW = $clog2(MAX_NOTES * 4);
	localparam int DW = $clog2(MAX_NOTES * 4 + 1);

	// Configuration and persistent state.
	logic [arp_pkg::PATTERN_W-1:0] pattern_q;
	logic [arp_pkg::SPAN_W-1:0]    span_q;
	logic [arp_pkg::TPS_W-1:0]     tps_q;
	logic [NW-1:0]                 n_q;
	logic [SW-1:0]                 sp_q;
	logic                          bounce_q;
	logic [arp_pkg::LCG_W-1:0]     lcg_q;
	logic [arp_pkg::PLAY_W-1:0]    cur_note_q;
	logic                          cur_valid_q;
	logic [arp_pkg::TPS_W-1:0]     tick_q;
	logic                          out_valid_q;

	// Working registers of the request in progress.
	logic [arp_pkg::MODE_W-1:0]    kind_q;
	logic [arp_pkg::NOTE_W-1:0]    note_q;
	logic [NW-1:0]                 i_q;
	logic [NW-1:0]                 pos_q;
	logic [SW-1:0]                 p_q;
	logic [IW-1:0]                 idx_q;
	logic [arp_pkg::OCT_W-1:0]     oct_q;
	logic                          started_q;
	logic                          out_nvalid_q;
	logic [arp_pkg::PLAY_W-1:0]    out_note_q;
	logic                          out_started_q;
	logic [NW-1:0]                 out_count_q;

	logic [arp_pkg::SPAN_W-1:0]    span_used;
	logic [DW-1:0]                 total;
	logic [arp_pkg::TPS_W-1:0]     period;
	logic [arp_pkg::TPS_W-1:0]     tick_next;
	logic                          boundary;
	logic                          step_go;
	logic                          rem_end;

	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [arp_pkg::NOTE_W-1:0]    ram_wdata;
	logic [NW-1:0]                 rd_ptr;
	logic [arp_pkg::NOTE_W-1:0]    rd_data;

	logic                          div_start;
	logic [arp_pkg::LCG_W-1:0]     div_dividend;
	logic [DW-1:0]                 div_divisor;
	logic                          div_done;
	logic [arp_pkg::LCG_W-1:0]     div_quot;
	logic [DW-1:0]                 div_rem;

	logic [DW-1:0]                 p_next;
	logic [NW-1:0]                 r_n;
	logic [NW-1:0]                 r_next;
	logic [SW-1:0]                 nm1;
	logic [SW-1:0]                 pb;
	logic                          nvalid;

	always_comb begin
		if (span_q < arp_pkg::SPAN_MIN) begin
			span_used = arp_pkg::SPAN_MIN;
		end else if (span_q > arp_pkg::SPAN_MAX) begin
			span_used = arp_pkg::SPAN_MAX;
		end else begin
			span_used = span_q;
		end
	end

	assign total     = DW'(n_q) * DW'(span_used);
	assign period    = (tps_q == '0) ? arp_pkg::TPS_W'(1) : tps_q;
	assign tick_next = tick_q + arp_pkg::TPS_W'(1);
	assign boundary  = tick_next >= period;
	assign step_go   = boundary && (n_q != '0);
	assign rem_end   = ({1'b0, i_q} + (NW+1)'(1)) >= {1'b0, n_q};

	assign p_next = DW'(p_q) + DW'(1);
	assign r_n    = NW'(div_rem);
	assign r_next = r_n + NW'(1);
	assign nm1    = SW'(n_q) - SW'(1);
	assign pb     = (sp_q > nm1) ? nm1 : sp_q;
	assign nvalid = (n_q != '0) && cur_valid_q;

	// Note table port selection.
	always_comb begin
		case (cmd.op)
			arp_pkg::OP_INS_RD:  rd_ptr = i_q - NW'(1);
			arp_pkg::OP_REM_RD:  rd_ptr = i_q + NW'(1);
			arp_pkg::OP_PICK_RD: rd_ptr = NW'(idx_q);
			default:             rd_ptr = i_q;
		endcase
	end

	assign ram_we    = (cmd.op == arp_pkg::OP_INS_WR) || (cmd.op == arp_pkg::OP_INS_NOTE) ||
	                   (cmd.op == arp_pkg::OP_REM_WR);
	assign ram_waddr = (cmd.op == arp_pkg::OP_INS_NOTE) ? pos_q[IW-1:0] : i_q[IW-1:0];
	assign ram_wdata = (cmd.op == arp_pkg::OP_INS_NOTE) ? note_q : rd_data;

	arp_ram #(
		.WIDTH(arp_pkg::NOTE_W),
		.DEPTH(MAX_NOTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_ptr[IW-1:0]),
		.rdata (rd_data)
	);

	// Divider operand selection.
	always_comb begin
		div_start    = 1'b1;
		div_dividend = arp_pkg::LCG_W'(sp_q);
		div_divisor  = DW'(n_q);
		case (cmd.op)
			arp_pkg::OP_DIV_SP_TOTAL: div_divisor = total;
			arp_pkg::OP_DIV_P_N:      div_dividend = arp_pkg::LCG_W'(p_q);
			arp_pkg::OP_DIV_SP_N:     div_dividend = arp_pkg::LCG_W'(sp_q);
			arp_pkg::OP_DIV_LCG_N:    div_dividend = lcg_q;
			arp_pkg::OP_DIV_LCGH_S: begin
				div_dividend = lcg_q >> arp_pkg::LCG_HI_SHIFT;
				div_divisor  = DW'(span_used);
			end
			default:                  div_start = 1'b0;
		endcase
	end

	arp_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= arp_pkg::PAT_UP;
			span_q      <= arp_pkg::SPAN_RESET;
			tps_q       <= arp_pkg::TPS_RESET;
			n_q         <= '0;
			sp_q        <= '0;
			bounce_q    <= 1'b0;
			lcg_q       <= arp_pkg::LCG_SEED;
			cur_note_q  <= '0;
			cur_valid_q <= 1'b0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					arp_pkg::REG_PATTERN: pattern_q <= cfg_data[arp_pkg::PATTERN_W-1:0];
					arp_pkg::REG_SPAN:    span_q    <= cfg_data[arp_pkg::SPAN_W-1:0];
					arp_pkg::REG_TPS:     tps_q     <= cfg_data[arp_pkg::TPS_W-1:0];
					default: ;
				endcase
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				arp_pkg::OP_INS_NOTE: n_q <= n_q + NW'(1);
				arp_pkg::OP_REM_END:  n_q <= n_q - NW'(1);
				arp_pkg::OP_TICK:     tick_q <= boundary ? '0 : tick_next;
				arp_pkg::OP_TAKE_UPDN: sp_q <= (p_next == total) ? '0 : SW'(p_next);
				arp_pkg::OP_TAKE_ASPL: sp_q <= (r_next == n_q) ? '0 : SW'(r_next);
				arp_pkg::OP_LCG:      lcg_q <= lcg_q * arp_pkg::LCG_MUL + arp_pkg::LCG_ADD;
				arp_pkg::OP_BOUNCE: begin
					// Turn at either end of the table, holding the top note once.
					if (!bounce_q) begin
						if (pb >= nm1) begin
							bounce_q <= 1'b1;
							sp_q     <= pb;
						end else begin
							sp_q <= pb + SW'(1);
						end
					end else if (pb == '0) begin
						bounce_q <= 1'b0;
						sp_q     <= SW'(1);
					end else begin
						sp_q <= pb - SW'(1);
					end
				end
				arp_pkg::OP_PICK_NOTE: begin
					cur_note_q  <= arp_pkg::PLAY_W'(rd_data) + arp_pkg::PLAY_W'(oct_q);
					cur_valid_q <= 1'b1;
				end
				arp_pkg::OP_FINISH:   out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			arp_pkg::OP_LOAD: begin
				kind_q    <= in_mode;
				note_q    <= in_note;
				i_q       <= '0;
				pos_q     <= '0;
				started_q <= 1'b0;
			end
			arp_pkg::OP_SCAN_CHK: begin
				if (rd_data != note_q) begin
					i_q <= i_q + NW'(1);
				end
				if (rd_data < note_q) begin
					pos_q <= pos_q + NW'(1);
				end
			end
			arp_pkg::OP_INS_WR: i_q <= i_q - NW'(1);
			arp_pkg::OP_REM_WR: i_q <= i_q + NW'(1);
			arp_pkg::OP_TICK:   started_q <= step_go;
			arp_pkg::OP_TAKE_P: p_q <= SW'(div_rem);
			arp_pkg::OP_TAKE_UPDN: begin
				idx_q <= (pattern_q == arp_pkg::PAT_DOWN) ? IW'(n_q - NW'(1) - r_n) : IW'(r_n);
				oct_q <= arp_pkg::octave_offset(div_quot[1:0]);
			end
			arp_pkg::OP_TAKE_RIDX: idx_q <= IW'(div_rem);
			arp_pkg::OP_TAKE_ROCT: oct_q <= arp_pkg::octave_offset(div_rem[1:0]);
			arp_pkg::OP_TAKE_ASPL: begin
				idx_q <= IW'(div_rem);
				oct_q <= '0;
			end
			arp_pkg::OP_BOUNCE: begin
				idx_q <= IW'(pb);
				oct_q <= '0;
			end
			arp_pkg::OP_FIXED: begin
				idx_q <= '0;
				oct_q <= '0;
			end
			arp_pkg::OP_FINISH: begin
				out_nvalid_q  <= nvalid;
				out_note_q    <= nvalid ? cur_note_q : '0;
				out_started_q <= started_q;
				out_count_q   <= n_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.kind     = kind_q;
		sts.pattern  = pattern_q;
		sts.n_zero   = (n_q == '0);
		sts.n_full   = (n_q >= NW'(MAX_NOTES));
		sts.match    = (rd_data == note_q);
		sts.last     = (i_q == n_q - NW'(1));
		sts.at_pos   = (i_q == pos_q);
		sts.rem_end  = rem_end;
		sts.step_go  = step_go;
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_nvalid  = out_nvalid_q;
	assign out_note    = out_note_q;
	assign out_started = out_started_q;
	assign out_count   = out_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_NOTES))
		else $error("held note count above table size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == arp_pkg::OP_INS_NOTE) |=> (n_q == $past(n_q) + NW'(1)))
		else $error("insertion did not grow the table by one");

	a_pick_needs_notes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == arp_pkg::OP_PICK_NOTE) |-> (n_q != '0))
		else $error("note picked from an empty table");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == arp_pkg::OP_FINISH) |-> (!out_valid_q || out_ready))
		else $error("result overwrote one still waiting");

endmodule

### src/arp_ctrl.sv
// Controller state machine of the arpeggiator.
// Sequences table scans, shifts, division steps and the output load. Depends on arp_pkg.
module arp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  arp_pkg::arp_sts_t sts,
	output arp_pkg::arp_cmd_t cmd
);

	arp_pkg::ctrl_state_t state_q;
	arp_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = arp_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			arp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = arp_pkg::OP_LOAD;
					state_d = arp_pkg::ST_DECODE;
				end
			end
			arp_pkg::ST_DECODE: begin
				case (sts.kind)
					arp_pkg::KIND_ON: begin
						if (sts.n_full) begin
							state_d = arp_pkg::ST_FINISH;
						end else if (sts.n_zero) begin
							state_d = arp_pkg::ST_INS_RD;
						end else begin
							state_d = arp_pkg::ST_SCAN_RD;
						end
					end
					arp_pkg::KIND_OFF: begin
						state_d = sts.n_zero ? arp_pkg::ST_FINISH : arp_pkg::ST_SCAN_RD;
					end
					arp_pkg::KIND_TICK: state_d = arp_pkg::ST_TICK;
					default:            state_d = arp_pkg::ST_FINISH;
				endcase
			end
			arp_pkg::ST_SCAN_RD: begin
				cmd.op  = arp_pkg::OP_SCAN_RD;
				state_d = arp_pkg::ST_SCAN_CHK;
			end
			arp_pkg::ST_SCAN_CHK: begin
				cmd.op = arp_pkg::OP_SCAN_CHK;
				if (sts.kind == arp_pkg::KIND_ON) begin
					// A note already held ends the request unchanged.
					if (sts.match) begin
						state_d = arp_pkg::ST_FINISH;
					end else if (sts.last) begin
						state_d = arp_pkg::ST_INS_RD;
					end else begin
						state_d = arp_pkg::ST_SCAN_RD;
					end
				end else begin
					if (sts.match) begin
						state_d = arp_pkg::ST_REM_RD;
					end else if (sts.last) begin
						state_d = arp_pkg::ST_FINISH;
					end else begin
						state_d = arp_pkg::ST_SCAN_RD;
					end
				end
			end
			arp_pkg::ST_INS_RD: begin
				if (sts.at_pos) begin
					cmd.op  = arp_pkg::OP_INS_NOTE;
					state_d = arp_pkg::ST_FINISH;
				end else begin
					cmd.op  = arp_pkg::OP_INS_RD;
					state_d = arp_pkg::ST_INS_WR;
				end
			end
			arp_pkg::ST_INS_WR: begin
				cmd.op  = arp_pkg::OP_INS_WR;
				state_d = arp_pkg::ST_INS_RD;
			end
			arp_pkg::ST_REM_RD: begin
				if (sts.rem_end) begin
					cmd.op  = arp_pkg::OP_REM_END;
					state_d = arp_pkg::ST_FINISH;
				end else begin
					cmd.op  = arp_pkg::OP_REM_RD;
					state_d = arp_pkg::ST_REM_WR;
				end
			end
			arp_pkg::ST_REM_WR: begin
				cmd.op  = arp_pkg::OP_REM_WR;
				state_d = arp_pkg::ST_REM_RD;
			end
			arp_pkg::ST_TICK: begin
				cmd.op  = arp_pkg::OP_TICK;
				state_d = sts.step_go ? arp_pkg::ST_STEP : arp_pkg::ST_FINISH;
			end
			arp_pkg::ST_STEP: begin
				case (sts.pattern)
					arp_pkg::PAT_UP, arp_pkg::PAT_DOWN, arp_pkg::PAT_PLAYED:
						state_d = arp_pkg::ST_DIV1;
					arp_pkg::PAT_UPDOWN: state_d = arp_pkg::ST_BOUNCE;
					arp_pkg::PAT_RANDOM: state_d = arp_pkg::ST_LCG;
					default:             state_d = arp_pkg::ST_FIXED;
				endcase
			end
			arp_pkg::ST_LCG: begin
				cmd.op  = arp_pkg::OP_LCG;
				state_d = arp_pkg::ST_DIV1;
			end
			arp_pkg::ST_DIV1: begin
				case (sts.pattern)
					arp_pkg::PAT_RANDOM: cmd.op = arp_pkg::OP_DIV_LCG_N;
					arp_pkg::PAT_PLAYED: cmd.op = arp_pkg::OP_DIV_SP_N;
					default:             cmd.op = arp_pkg::OP_DIV_SP_TOTAL;
				endcase
				state_d = arp_pkg::ST_WAIT1;
			end
			arp_pkg::ST_WAIT1: begin
				if (sts.div_done) begin
					state_d = arp_pkg::ST_TAKE1;
				end
			end
			arp_pkg::ST_TAKE1: begin
				case (sts.pattern)
					arp_pkg::PAT_RANDOM: cmd.op = arp_pkg::OP_TAKE_RIDX;
					arp_pkg::PAT_PLAYED: cmd.op = arp_pkg::OP_TAKE_ASPL;
					default:             cmd.op = arp_pkg::OP_TAKE_P;
				endcase
				state_d = (sts.pattern == arp_pkg::PAT_PLAYED) ? arp_pkg::ST_PICK_RD :
				                                                  arp_pkg::ST_DIV2;
			end
			arp_pkg::ST_DIV2: begin
				cmd.op  = (sts.pattern == arp_pkg::PAT_RANDOM) ? arp_pkg::OP_DIV_LCGH_S :
				                                                  arp_pkg::OP_DIV_P_N;
				state_d = arp_pkg::ST_WAIT2;
			end
			arp_pkg::ST_WAIT2: begin
				if (sts.div_done) begin
					state_d = arp_pkg::ST_TAKE2;
				end
			end
			arp_pkg::ST_TAKE2: begin
				cmd.op  = (sts.pattern == arp_pkg::PAT_RANDOM) ? arp_pkg::OP_TAKE_ROCT :
				                                                  arp_pkg::OP_TAKE_UPDN;
				state_d = arp_pkg::ST_PICK_RD;
			end
			arp_pkg::ST_BOUNCE: begin
				cmd.op  = arp_pkg::OP_BOUNCE;
				state_d = arp_pkg::ST_PICK_RD;
			end
			arp_pkg::ST_FIXED: begin
				cmd.op  = arp_pkg::OP_FIXED;
				state_d = arp_pkg::ST_PICK_RD;
			end
			arp_pkg::ST_PICK_RD: begin
				cmd.op  = arp_pkg::OP_PICK_RD;
				state_d = arp_pkg::ST_PICK_NOTE;
			end
			arp_pkg::ST_PICK_NOTE: begin
				cmd.op  = arp_pkg::OP_PICK_NOTE;
				state_d = arp_pkg::ST_FINISH;
			end
			arp_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.op  = arp_pkg::OP_FINISH;
					state_d = arp_pkg::ST_IDLE;
				end
			end
			default: state_d = arp_pkg::ST_IDLE;
		endcase
	end

endmodule

### src/midi_note_arpeggiator.sv
// MIDI note arpeggiator. Each request is a note-on, a note-off or a time tick; each one
// returns exactly one result with the current note, whether a step began and how many notes
// are held. Requests are handled one at a time: a note-on or note-off scans the table with a
// read and a compare per table entry, then moves each shifted entry with a read and a write,
// through the one-read, one-write note table; a step in the as-played pattern waits on one
// division and a step in the up, down and random patterns on two, each modulo worked out by
// the shared shift-subtract divider, while the bounce pattern and an unused pattern need no
// division. The result register lets the next request be taken while a result still waits
// downstream. The note table needs no clearing after reset. Configuration is written through
// cfg_we, cfg_index and cfg_data.
// Depends on arp_pkg, arp_ctrl and arp_dp.
module midi_note_arpeggiator #(
	parameter int MAX_NOTES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [6:0] note_number
	input  logic [arp_pkg::MODE_W-1:0]     s_tuser,  // [1:0] mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] play_note, then held_count
	output logic [((arp_pkg::PLAY_W + $clog2(MAX_NOTES+1) + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0]                     m_tuser,  // [0] note_valid, [1] step_started
	input  logic                           cfg_we,
	input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NW  = $clog2(MAX_NOTES + 1);
	localparam int TDW = ((arp_pkg::PLAY_W + NW + 7) / 8) * 8;

	arp_pkg::arp_cmd_t          cmd;
	arp_pkg::arp_sts_t          sts;
	logic                       out_nvalid;
	logic [arp_pkg::PLAY_W-1:0] out_note;
	logic                       out_started;
	logic [NW-1:0]              out_count;

	arp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arp_dp #(
		.MAX_NOTES(MAX_NOTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_mode     (s_tuser),
		.in_note     (s_tdata[arp_pkg::NOTE_W-1:0]),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_nvalid  (out_nvalid),
		.out_note    (out_note),
		.out_started (out_started),
		.out_count   (out_count)
	);

	assign m_tdata = TDW'({out_count, out_note});
	assign m_tuser = {out_started, out_nvalid};

endmodule
